>>> src/pdds_pkg.sv
package pdds_pkg;

	localparam int SLOTS_DEFAULT = 8;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_ON   = 2'd1,
		OP_OFF  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		WAVE_SQUARE   = 2'd0,
		WAVE_TRIANGLE = 2'd1,
		WAVE_SAW      = 2'd2,
		WAVE_SINE     = 2'd3
	} wave_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_DRAIN,
		S_EMIT,
		S_SCAN
	} ctrl_state_t;

	typedef struct packed {
		logic [15:0] phase;
		logic [14:0] step;
		logic [1:0]  voice;
		logic [6:0]  note;
	} slot_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic cnt_inc;
		logic wr_idle;
		logic wr_rot;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_last;
		logic slot_idle;
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

	localparam logic [15:0] LEVEL_HIGH = 16'h1000;
	localparam logic [15:0] LEVEL_LOW  = 16'hF000;
	localparam logic [15:0] TRI_PEAK   = 16'h3000;

	localparam logic [14:0] STEP_TABLE [128] = '{
		15'd17, 15'd18, 15'd19, 15'd20, 15'd22, 15'd23, 15'd24, 15'd26,
		15'd27, 15'd29, 15'd31, 15'd32, 15'd34, 15'd36, 15'd38, 15'd41,
		15'd43, 15'd46, 15'd48, 15'd51, 15'd54, 15'd58, 15'd61, 15'd65,
		15'd69, 15'd73, 15'd77, 15'd82, 15'd86, 15'd92, 15'd97, 15'd103,
		15'd109, 15'd115, 15'd122, 15'd129, 15'd137, 15'd145, 15'd154, 15'd163,
		15'd173, 15'd183, 15'd194, 15'd206, 15'd218, 15'd231, 15'd244, 15'd259,
		15'd274, 15'd291, 15'd308, 15'd326, 15'd346, 15'd366, 15'd388, 15'd411,
		15'd435, 15'd461, 15'd489, 15'd518, 15'd549, 15'd581, 15'd616, 15'd652,
		15'd691, 15'd732, 15'd776, 15'd822, 15'd871, 15'd923, 15'd978, 15'd1036,
		15'd1097, 15'd1163, 15'd1232, 15'd1305, 15'd1383, 15'd1465, 15'd1552, 15'd1644,
		15'd1742, 15'd1845, 15'd1955, 15'd2071, 15'd2195, 15'd2325, 15'd2463, 15'd2610,
		15'd2765, 15'd2930, 15'd3104, 15'd3288, 15'd3484, 15'd3691, 15'd3910, 15'd4143,
		15'd4389, 15'd4650, 15'd4927, 15'd5220, 15'd5530, 15'd5859, 15'd6207, 15'd6577,
		15'd6968, 15'd7382, 15'd7821, 15'd8286, 15'd8779, 15'd9301, 15'd9854, 15'd10440,
		15'd11060, 15'd11718, 15'd12415, 15'd13153, 15'd13935, 15'd14764, 15'd15642,
		15'd16572, 15'd17557, 15'd18601, 15'd19708, 15'd20879, 15'd22121, 15'd23436,
		15'd24830, 15'd26306
	};

	// First half of one sine period; the second half is its negation.
	localparam logic [13:0] HALF_SINE [128] = '{
		14'd0, 14'd201, 14'd402, 14'd603, 14'd803, 14'd1003, 14'd1202, 14'd1401,
		14'd1598, 14'd1795, 14'd1990, 14'd2185, 14'd2378, 14'd2570, 14'd2760, 14'd2948,
		14'd3135, 14'd3320, 14'd3503, 14'd3683, 14'd3862, 14'd4038, 14'd4212, 14'd4383,
		14'd4551, 14'd4717, 14'd4880, 14'd5040, 14'd5197, 14'd5351, 14'd5501, 14'd5649,
		14'd5793, 14'd5933, 14'd6070, 14'd6203, 14'd6333, 14'd6458, 14'd6580, 14'd6698,
		14'd6811, 14'd6921, 14'd7027, 14'd7128, 14'd7225, 14'd7317, 14'd7405, 14'd7489,
		14'd7568, 14'd7643, 14'd7713, 14'd7779, 14'd7839, 14'd7895, 14'd7946, 14'd7993,
		14'd8035, 14'd8071, 14'd8103, 14'd8130, 14'd8153, 14'd8170, 14'd8182, 14'd8190,
		14'd8192, 14'd8190, 14'd8182, 14'd8170, 14'd8153, 14'd8130, 14'd8103, 14'd8071,
		14'd8035, 14'd7993, 14'd7946, 14'd7895, 14'd7839, 14'd7779, 14'd7713, 14'd7643,
		14'd7568, 14'd7489, 14'd7405, 14'd7317, 14'd7225, 14'd7128, 14'd7027, 14'd6921,
		14'd6811, 14'd6698, 14'd6580, 14'd6458, 14'd6333, 14'd6203, 14'd6070, 14'd5933,
		14'd5793, 14'd5649, 14'd5501, 14'd5351, 14'd5197, 14'd5040, 14'd4880, 14'd4717,
		14'd4551, 14'd4383, 14'd4212, 14'd4038, 14'd3862, 14'd3683, 14'd3503, 14'd3320,
		14'd3135, 14'd2948, 14'd2760, 14'd2570, 14'd2378, 14'd2185, 14'd1990, 14'd1795,
		14'd1598, 14'd1401, 14'd1202, 14'd1003, 14'd803, 14'd603, 14'd402, 14'd201
	};

	// All arithmetic is modulo 2^16, which matches the wrapped sum.
	function automatic logic [15:0] wave_sample(wave_t shape, logic [15:0] p);
		logic [15:0] quarter;
		logic [15:0] eighth;
		logic [15:0] sine_mag;
		logic [15:0] res;
		quarter  = {2'b00, p[15:2]};
		eighth   = {3'b000, p[15:3]};
		sine_mag = {2'b00, HALF_SINE[p[14:8]]};
		unique case (shape)
			WAVE_SQUARE:   res = p[15] ? LEVEL_HIGH : LEVEL_LOW;
			WAVE_TRIANGLE: res = p[15] ? (TRI_PEAK - quarter) : (LEVEL_LOW + quarter);
			WAVE_SAW:      res = LEVEL_LOW + eighth;
			WAVE_SINE:     res = p[15] ? (16'd0 - sine_mag) : sine_mag;
		endcase
		return res;
	endfunction

endpackage

>>> src/pdds_ram.sv
module pdds_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/pdds_ctrl.sv
module pdds_ctrl
	import pdds_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] operation,
	input  dp_status_t st,
	output logic       item_ready,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					if (operation == OP_TICK || operation == OP_OFF) begin
						state_d = S_SWEEP;
					end else if (operation == OP_ON) begin
						state_d = S_SCAN;
					end
				end
			end
			S_SWEEP: begin
				cmd.rd      = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (st.cnt_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!st.pipe_busy) begin
					state_d = (st.op == OP_TICK) ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_SCAN: begin
				// The lowest idle slot wins; with none idle the round-robin slot is taken.
				priority if (st.slot_idle) begin
					cmd.wr_idle = 1'b1;
					state_d     = S_IDLE;
				end else if (st.cnt_last) begin
					cmd.wr_rot = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> src/pdds_dp.sv
module pdds_dp
	import pdds_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  operation,
	input  logic [1:0]  voice,
	input  logic [6:0]  note,
	input  logic [6:0]  velocity,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  st,
	input  logic        sample_ready,
	output logic        sample_valid,
	output logic [15:0] sample
);

	localparam int AW = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int SW = $bits(slot_t);
	localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

	wave_t          wave_q [4];
	logic [SLOTS-1:0] active_q;
	logic [AW-1:0]  rot_q;
	logic [AW-1:0]  cnt_q;
	op_t            op_q;
	logic [1:0]     voice_q;
	logic [6:0]     note_q;
	logic           vel_nz_q;

	logic           v_s1_q;
	logic [AW-1:0]  addr_s1_q;
	logic           v_s2_q;
	logic [15:0]    phase_s2_q;
	wave_t          shape_s2_q;

	logic [15:0]    sum_q;
	logic           sample_valid_q;
	logic [15:0]    sample_q;

	logic [SW-1:0]  rd_raw;
	slot_t          rd_slot;
	slot_t          new_slot;
	slot_t          wr_slot;
	logic [AW-1:0]  waddr;
	logic           we;
	logic [AW-1:0]  pick;
	logic [15:0]    next_phase;
	logic           tick_wb;
	logic           off_hit;
	logic           on_wr;

	assign rd_slot    = slot_t'(rd_raw);
	assign next_phase = rd_slot.phase + {1'b0, rd_slot.step};
	assign tick_wb    = v_s1_q && (op_q == OP_TICK);
	assign off_hit    = v_s1_q && (op_q == OP_OFF) && (rd_slot.voice == voice_q)
		&& (rd_slot.note == note_q);
	assign on_wr      = cmd.wr_idle || cmd.wr_rot;
	assign pick       = cmd.wr_idle ? cnt_q : rot_q;

	always_comb begin
		new_slot.phase = '0;
		new_slot.step  = STEP_TABLE[note_q];
		new_slot.voice = voice_q;
		new_slot.note  = note_q;
		wr_slot        = rd_slot;
		wr_slot.phase  = next_phase;
		waddr          = addr_s1_q;
		we             = tick_wb;
		if (on_wr) begin
			wr_slot = new_slot;
			waddr   = pick;
			we      = 1'b1;
		end
	end

	pdds_ram #(
		.WIDTH(SW),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(SW'(wr_slot)),
		.re   (cmd.rd),
		.raddr(cnt_q),
		.rdata(rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q[0] <= WAVE_SQUARE;
			wave_q[1] <= WAVE_TRIANGLE;
			wave_q[2] <= WAVE_SAW;
			wave_q[3] <= WAVE_SINE;
		end else if (cfg_write) begin
			wave_q[cfg_index] <= wave_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= '0;
			rot_q          <= '0;
			cnt_q          <= '0;
			v_s1_q         <= 1'b0;
			v_s2_q         <= 1'b0;
			sample_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// Only active slots enter the tick pipeline; note-off checks every slot.
			v_s1_q <= cmd.rd && ((op_q != OP_TICK) || active_q[cnt_q]);
			v_s2_q <= tick_wb;
			if (off_hit) begin
				active_q[addr_s1_q] <= 1'b0;
			end
			if (on_wr) begin
				active_q[pick] <= vel_nz_q;
				rot_q          <= (pick == LAST_SLOT) ? '0 : pick + 1'b1;
			end
			if (cmd.out_load) begin
				sample_valid_q <= 1'b1;
			end else if (sample_ready) begin
				sample_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(operation);
			voice_q  <= voice;
			note_q   <= note;
			vel_nz_q <= (velocity != '0);
		end
		addr_s1_q  <= cnt_q;
		phase_s2_q <= next_phase;
		shape_s2_q <= wave_q[rd_slot.voice];
		if (cmd.load) begin
			sum_q <= '0;
		end else if (v_s2_q) begin
			sum_q <= sum_q + wave_sample(shape_s2_q, phase_s2_q);
		end
		if (cmd.out_load) begin
			sample_q <= sum_q;
		end
	end

	assign st.op        = op_q;
	assign st.cnt_last  = (cnt_q == LAST_SLOT);
	assign st.slot_idle = !active_q[cnt_q];
	assign st.pipe_busy = v_s1_q || v_s2_q;
	assign st.out_free  = !sample_valid_q || sample_ready;

	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;

	a_idle_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_idle |-> !active_q[cnt_q])
		else $error("note-on claimed a slot that is still active");

	a_on_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(on_wr && vel_nz_q) |=> active_q[$past(pick)])
		else $error("note-on with velocity did not activate its slot");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!v_s1_q && !v_s2_q))
		else $error("sample emitted before the slot sweep drained");

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		rot_q <= LAST_SLOT)
		else $error("round-robin pointer beyond the last slot");

endmodule

>>> src/polyphonic_dds_synth.sv
// Polyphonic oscillator bank: SLOTS phase-accumulator slots shared by four voices, each
// voice with a waveform register (square, triangle, sawtooth or sine). Items are taken
// one at a time. A tick walks the slot memory one slot per cycle through a single read
// port, updates each active slot's phase and returns the wrapped 16-bit mix. The pipeline
// must drain before the mix is final; the mix then enters the output register once the
// previous sample has been taken, and only then can the next item be accepted. A note-off
// makes the same walk and drain without a result. A note-on scans the active flags one
// slot per cycle for the lowest idle slot, taking the round-robin slot if none is idle.
// A finished sample waits in an output register while the next request is accepted.
// Slot data needs no clearing after reset; waveform registers may be written whenever
// the block is idle.
module polyphonic_dds_synth
	import pdds_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  operation,
	input  logic [1:0]  voice,
	input  logic [6:0]  note,
	input  logic [6:0]  velocity,
	output logic        sample_valid,
	input  logic        sample_ready,
	output logic [15:0] sample,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	pdds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.operation (operation),
		.st        (st),
		.item_ready(item_ready),
		.cmd       (cmd)
	);

	pdds_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.voice       (voice),
		.note        (note),
		.velocity    (velocity),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.sample_ready(sample_ready),
		.sample_valid(sample_valid),
		.sample      (sample)
	);

endmodule
